FILE: design/htqp_pkg.sv
// ----------------------------------------------------------------------------
// htqp_pkg
// Shared types, codes and sizes for the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package htqp_pkg;

    // Table geometry
    localparam int SLOTS      = 1024;
    localparam int MAX_PROBES = 64;
    localparam int KEY_BYTES  = 8;

    // Fixed field widths
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 10;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 8;
    localparam int HASH_W  = 64;

    // Derived widths
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int N_W      = $clog2(MAX_PROBES);
    localparam int SQ_W     = 2 * N_W;
    localparam int SUM_W    = ((SQ_W > IDX_W) ? SQ_W : IDX_W) + 1;
    localparam int STEP_W   = $clog2(HASH_W + 1);
    localparam int BYTE_W   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    // djb2 seed
    localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FIRST  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_PROBE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_END      = 3'd4;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_TABLE_SIZE = 8'd0;
    localparam logic [CIDX_W-1:0] REG_LOAD_LIMIT = 8'd1;

    // One stored slot
    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HMOD,
        S_READ,
        S_CHECK,
        S_PMOD,
        S_WALK,
        S_WCHK,
        S_DONE
    } state_t;

endpackage

FILE: design/htqp_hash.sv
// ----------------------------------------------------------------------------
// htqp_hash
// djb2 hash over the key bytes, one byte per cycle, A..Z folded to lower case.
// ----------------------------------------------------------------------------
module htqp_hash
    import htqp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEY_W-1:0]  key,
    output logic              done,
    output logic [HASH_W-1:0] h
);

    logic              busy_reg;
    logic              done_reg;
    logic [BYTE_W-1:0] b_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [HASH_W-1:0] h_reg;
    logic [7:0]        c;
    logic [7:0]        lc;
    logic              last;

    // Select current byte and fold case
    assign c    = key_reg[{b_reg, 3'b000} +: 8];
    assign lc   = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    assign last = (c == 8'h00) || (b_reg == BYTE_W'(KEY_BYTES - 1));

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
            h_reg   <= HASH_SEED;
            b_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (c != 8'h00)
            begin
                h_reg <= (h_reg << 5) + h_reg + HASH_W'(lc);
            end
            b_reg <= b_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign h    = h_reg;

endmodule

FILE: design/htqp_mod.sv
// ----------------------------------------------------------------------------
// htqp_mod
// Restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module htqp_mod
    import htqp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [STEP_W-1:0] steps,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  rem
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [HASH_W-1:0] dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W:0]    t;
    logic [CNT_W-1:0]  rem_next;

    // Shift in next bit and conditionally subtract
    always_comb
    begin
        t = {rem_reg, dvd_reg[HASH_W-1]};
        if (t >= {1'b0, div_reg})
        begin
            rem_next = CNT_W'(t - {1'b0, div_reg});
        end
        else
        begin
            rem_next = CNT_W'(t);
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: design/hash_table_quadratic_probe_top.sv
// ----------------------------------------------------------------------------
// hash_table_quadratic_probe_top
// Open-addressing key/value table with djb2 hash and quadratic probing.
// ----------------------------------------------------------------------------
// Flow: insert/lookup/remove hash the key and reduce the hash modulo the table size,
//   then read and check one slot per probe, with a shorter modulo pass before each
//   extra probe; first/next read and check slots in turn; every item ends on the output.
// Throughput: one item at a time, the next one taken once the result is
//   registered; the serial hash and modulo units set the pace.
// Reset: a clearing pass over every slot empties the table; items wait, config writes do not.
module hash_table_quadratic_probe_top
    import htqp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input: key [63:0], value [95:64]
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [95:0]        s_tdata,
    // input: func [2:0]
    input  logic [2:0]         s_tuser,
    // output: found_value [31:0], found_key [95:32], slot_index [105:96],
    //         entry_count [116:106]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [119:0]       m_tdata,
    // output: status [2:0]
    output logic [2:0]         m_tuser,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  table_size_reg, load_limit_reg;
    logic [CNT_W-1:0]  size_eff;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [KEY_W-1:0]  key_reg, key_next, key_norm;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]  wptr_reg, wptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic [KEY_W-1:0]  res_key_reg, res_key_next;
    logic [IDX_W-1:0]  res_slot_reg, res_slot_next;

    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;
    logic [KEY_W-1:0]  m_key_reg, m_key_next;
    logic [IDX_W-1:0]  m_slot_reg, m_slot_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;

    // Slot memory
    entry_t            mem [SLOTS];
    entry_t            rd_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    entry_t            mem_wdata;

    logic              hash_start, hash_done;
    logic [HASH_W-1:0] hash_h;
    logic              mod_start, mod_done;
    logic [HASH_W-1:0] mod_dividend;
    logic [STEP_W-1:0] mod_steps;
    logic [CNT_W-1:0]  mod_rem;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W-1:0]  probe_sum;
    logic              hit;
    logic              accept;
    logic              out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Clamp table size to the legal range
    always_comb
    begin
        if (CNT_W'(table_size_reg) < CNT_W'(3))
        begin
            size_eff = CNT_W'(3);
        end
        else if (CNT_W'(table_size_reg) > CNT_W'(SLOTS))
        begin
            size_eff = CNT_W'(SLOTS);
        end
        else
        begin
            size_eff = CNT_W'(table_size_reg);
        end
    end

    // Zero every byte from the first zero byte on
    always_comb
    begin
        logic alive;
        alive    = 1'b1;
        key_norm = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (s_tdata[8*b +: 8] == 8'h00)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                key_norm[8*b +: 8] = s_tdata[8*b +: 8];
            end
        end
    end

    assign sq        = SQ_W'(n_reg) * SQ_W'(n_reg);
    assign probe_sum = SUM_W'(idx_reg) + SUM_W'(sq);
    assign hit       = !rd_reg.used || (rd_reg.key == key_reg);

    htqp_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_norm),
        .done  (hash_done),
        .h     (hash_h)
    );

    htqp_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .steps    (mod_steps),
        .divisor  (size_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == FN_INSERT || s_tuser == FN_LOOKUP
                        || s_tuser == FN_REMOVE)
                    begin
                        state_next = S_HASH;
                    end
                    else if (s_tuser == FN_FIRST || s_tuser == FN_NEXT)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_HMOD;
                end
            end
            S_HMOD, S_PMOD:
            begin
                if (mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hit || n_reg == N_W'(MAX_PROBES - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PMOD;
                end
            end
            S_WALK:
            begin
                if (wptr_reg >= size_eff)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (rd_reg.used)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        func_next       = func_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        wptr_next       = wptr_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_key_next    = res_key_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_key_next      = m_key_reg;
        m_slot_next     = m_slot_reg;
        m_count_next    = m_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_reg;
        mem_raddr       = idx_reg;
        hash_start      = 1'b0;
        mod_start       = 1'b0;
        mod_dividend    = hash_h;
        mod_steps       = STEP_W'(HASH_W);

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next       = s_tuser;
                    key_next        = key_norm;
                    val_next        = s_tdata[95:64];
                    n_next          = '0;
                    res_status_next = ST_NOTFOUND;
                    res_value_next  = '0;
                    res_key_next    = '0;
                    res_slot_next   = cursor_reg;
                    if (s_tuser == FN_FIRST)
                    begin
                        wptr_next = '0;
                    end
                    else
                    begin
                        wptr_next = CNT_W'(cursor_reg) + 1'b1;
                    end
                    hash_start = (s_tuser == FN_INSERT || s_tuser == FN_LOOKUP
                                  || s_tuser == FN_REMOVE);
                end
            end
            S_HASH:
            begin
                mod_start = hash_done;
            end
            S_HMOD, S_PMOD:
            begin
                if (mod_done)
                begin
                    idx_next = mod_rem[IDX_W-1:0];
                end
            end
            S_READ:
            begin
                mem_raddr = idx_reg;
            end
            S_CHECK:
            begin
                res_slot_next = idx_reg;
                if (hit)
                begin
                    case (func_reg)
                        FN_INSERT:
                        begin
                            if (!rd_reg.used)
                            begin
                                if (count_reg >= CNT_W'(load_limit_reg))
                                begin
                                    res_status_next = ST_FULL;
                                end
                                else
                                begin
                                    mem_we          = 1'b1;
                                    mem_wdata.used  = 1'b1;
                                    mem_wdata.key   = key_reg;
                                    mem_wdata.value = val_reg;
                                    count_next      = count_reg + 1'b1;
                                    res_status_next = ST_OK;
                                    res_value_next  = val_reg;
                                end
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_wdata.value = (rd_reg.value == '0) ? val_reg
                                                                       : rd_reg.value;
                                res_status_next = ST_OK;
                                res_value_next  = mem_wdata.value;
                            end
                        end
                        FN_LOOKUP:
                        begin
                            if (rd_reg.used && rd_reg.value != '0)
                            begin
                                cursor_next     = idx_reg;
                                res_status_next = ST_OK;
                                res_value_next  = rd_reg.value;
                            end
                        end
                        default:
                        begin
                            if (rd_reg.used)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata.used  = 1'b0;
                                res_status_next = ST_OK;
                                res_value_next  = rd_reg.value;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                    endcase
                end
                else if (n_reg == N_W'(MAX_PROBES - 1))
                begin
                    res_status_next = ST_PROBE;
                end
                else
                begin
                    mod_start    = 1'b1;
                    mod_dividend = {probe_sum, (HASH_W - SUM_W)'(0)};
                    mod_steps    = STEP_W'(SUM_W);
                    n_next       = n_reg + 1'b1;
                end
            end
            S_WALK:
            begin
                mem_raddr = wptr_reg[IDX_W-1:0];
                if (wptr_reg >= size_eff)
                begin
                    res_status_next = ST_END;
                    res_slot_next   = cursor_reg;
                end
            end
            S_WCHK:
            begin
                if (rd_reg.used)
                begin
                    cursor_next     = wptr_reg[IDX_W-1:0];
                    res_status_next = ST_OK;
                    res_value_next  = rd_reg.value;
                    res_key_next    = rd_reg.key;
                    res_slot_next   = wptr_reg[IDX_W-1:0];
                end
                else
                begin
                    wptr_next = wptr_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_key_next    = res_key_reg;
                    m_slot_next   = res_slot_reg;
                    m_count_next  = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Slot memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            count_reg      <= '0;
            cursor_reg     <= '0;
            m_valid_reg    <= 1'b0;
            table_size_reg <= CFG_W'(631);
            load_limit_reg <= CFG_W'(486);
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TABLE_SIZE: table_size_reg <= cfg_data;
                    REG_LOAD_LIMIT: load_limit_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        wptr_reg       <= wptr_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_key_reg    <= res_key_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_key_reg      <= m_key_next;
        m_slot_reg     <= m_slot_next;
        m_count_reg    <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_count_reg, SLOT_W'(m_slot_reg), m_key_reg, m_value_reg};

endmodule
